/* rtl/assert_macros.svh */
// Assertion macros for the RTL files of the rotation block; the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define HPR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define HPR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/hpr_pkg.sv */
// Package of the rotation block: widths, constants, types and arithmetic helpers.
`timescale 1ns / 1ps

package hpr_pkg;

    localparam int ANG_W          = 17;
    localparam int VEL_W          = 32;
    localparam int TRIG_FRAC_BITS = 18;

    localparam int CORDIC_BITS  = 30;
    localparam int CORDIC_ITERS = 30;
    localparam int CORDIC_W     = 32;
    localparam int SHIFT_W      = $clog2(CORDIC_ITERS);
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 32'sd652032874;

    localparam int TRIG_W = TRIG_FRAC_BITS + 2;
    localparam int COEF_W = TRIG_FRAC_BITS + 3;
    localparam int TERM_W = VEL_W + 2;
    localparam int SUM_W  = VEL_W + 4;

    // Angle to phase: a * 2^32 / 36000 split as a * 119304 + (a * 23296 + 18000) / 36000.
    localparam int TURN_CDEG = 36000;
    localparam int RED_W     = 16;
    localparam int PH_HI_MUL = 119304;
    localparam int PH_LO_MUL = 23296;
    localparam int PH_RND    = 18000;
    localparam int T_W       = 30;
    localparam int U_W       = 25;
    localparam int QE_W      = 15;
    localparam int DIV_REM   = 1125;
    localparam int RECIP_SH  = 40;
    localparam logic [29:0] RECIP_M = 30'd977343669;
    localparam int PH_STAGES = 4;

    localparam int ROT_STAGES = 6;
    localparam int NSTG       = PH_STAGES + CORDIC_ITERS + ROT_STAGES;
    localparam int VEL_DLY    = PH_STAGES + CORDIC_ITERS;

    localparam int IN_BITS  = 3 * ANG_W + 3 * VEL_W;
    localparam int IN_TW    = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_TW   = ((3 * VEL_W + 7) / 8) * 8;

    // atan(2^-i) in 2^-32 turn; the first entry is the 45 degree step.
    localparam logic [CORDIC_W-1:0] ATAN [CORDIC_ITERS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    typedef logic signed [TRIG_W-1:0] t_trig;
    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [TERM_W-1:0] t_term;

    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic signed [CORDIC_W-1:0] z;
        logic                       neg;
    } t_cord;

    typedef struct packed {
        logic signed [VEL_W-1:0] c2;
        logic signed [VEL_W-1:0] c1;
        logic signed [VEL_W-1:0] c0;
    } t_vec3;

    localparam int CSH = CORDIC_BITS - TRIG_FRAC_BITS;
    localparam logic [CORDIC_W:0] C_HALF =
        (CSH == 0) ? '0 : ((CORDIC_W + 1)'(1) << ((CSH > 0) ? CSH - 1 : 0));
    localparam logic [CORDIC_W:0] TRIG_LIM = (CORDIC_W + 1)'(1) << TRIG_FRAC_BITS;

    // CORDIC output to trig format: round half away from zero, clamp, apply fold sign.
    function automatic t_trig trig_fmt(logic signed [CORDIC_W-1:0] v, logic neg);
        logic [CORDIC_W:0] m;
        logic [CORDIC_W:0] r;
        t_trig             t;
        m = v[CORDIC_W-1] ? (CORDIC_W + 1)'(-v) : (CORDIC_W + 1)'(v);
        r = (m + C_HALF) >> CSH;
        if (r > TRIG_LIM) begin
            r = TRIG_LIM;
        end
        t = TRIG_W'(r);
        return (v[CORDIC_W-1] ^ neg) ? -t : t;
    endfunction

    localparam int TP_W = 2 * TRIG_W;

    // Product of two trig values, rounded back to trig format.
    function automatic t_trig tmul(t_trig a, t_trig b);
        logic signed [TP_W-1:0] p;
        logic [TP_W-1:0]        m;
        logic [TP_W-1:0]        r;
        t_trig                  t;
        p = TP_W'(a) * TP_W'(b);
        m = p[TP_W-1] ? -p : p;
        r = (m + (TP_W'(1) << (TRIG_FRAC_BITS - 1))) >> TRIG_FRAC_BITS;
        t = TRIG_W'(r);
        return p[TP_W-1] ? -t : t;
    endfunction

    localparam int VP_W = VEL_W + COEF_W;

    // Velocity times coefficient, rounded to the velocity format.
    function automatic t_term vmul(logic signed [VEL_W-1:0] v, t_coef c);
        logic signed [VP_W-1:0] p;
        logic [VP_W-1:0]        m;
        logic [VP_W-1:0]        r;
        t_term                  t;
        p = VP_W'(v) * VP_W'(c);
        m = p[VP_W-1] ? -p : p;
        r = (m + (VP_W'(1) << (TRIG_FRAC_BITS - 1))) >> TRIG_FRAC_BITS;
        t = TERM_W'(r);
        return p[VP_W-1] ? -t : t;
    endfunction

    function automatic logic signed [VEL_W-1:0] sat_vel(logic signed [SUM_W-1:0] s);
        logic [SUM_W-VEL_W:0] top;
        top = s[SUM_W-1:VEL_W-1];
        if (top == '0 || top == '1) begin
            return s[VEL_W-1:0];
        end
        return s[SUM_W-1] ? {1'b1, {(VEL_W - 1){1'b0}}} : {1'b0, {(VEL_W - 1){1'b1}}};
    endfunction

endpackage

/* rtl/hpr_phase.sv */
// Angle front end: reduction to one turn, conversion to a binary phase, quadrant fold.
`timescale 1ns / 1ps

module hpr_phase (
    input  logic                              i_clk,
    input  logic [hpr_pkg::PH_STAGES-1:0]     i_en,
    input  logic signed [hpr_pkg::ANG_W-1:0]  i_ang,
    output hpr_pkg::t_cord                    o_cord
);

    logic [hpr_pkg::RED_W-1:0]  r_a;
    logic [hpr_pkg::U_W-1:0]    r_u1;
    logic [31:0]                r_hi1;
    logic [hpr_pkg::QE_W-1:0]   r_qe;
    logic [hpr_pkg::U_W-1:0]    r_u2;
    logic [31:0]                r_hi2;
    hpr_pkg::t_cord             r_cord;

    logic signed [hpr_pkg::ANG_W:0] a_ext;
    logic [hpr_pkg::RED_W-1:0]      n_a;
    logic [hpr_pkg::T_W-1:0]        t_lo;
    logic [54:0]                    recip;
    logic [hpr_pkg::U_W-1:0]        rem;
    logic [hpr_pkg::QE_W-1:0]       q;
    logic [31:0]                    p;
    logic signed [32:0]             z0;
    hpr_pkg::t_cord                 n_cord;

    localparam logic signed [32:0] QTR_TURN  = 33'sd1 <<< 30;
    localparam logic signed [32:0] HALF_TURN = 33'sd1 <<< 31;

    always_comb begin
        a_ext = (hpr_pkg::ANG_W + 1)'(i_ang);
        if (a_ext < -(hpr_pkg::ANG_W + 1)'(hpr_pkg::TURN_CDEG)) begin
            n_a = hpr_pkg::RED_W'(a_ext + (hpr_pkg::ANG_W + 1)'(2 * hpr_pkg::TURN_CDEG));
        end else if (a_ext < 0) begin
            n_a = hpr_pkg::RED_W'(a_ext + (hpr_pkg::ANG_W + 1)'(hpr_pkg::TURN_CDEG));
        end else if (a_ext >= (hpr_pkg::ANG_W + 1)'(hpr_pkg::TURN_CDEG)) begin
            n_a = hpr_pkg::RED_W'(a_ext - (hpr_pkg::ANG_W + 1)'(hpr_pkg::TURN_CDEG));
        end else begin
            n_a = hpr_pkg::RED_W'(a_ext);
        end
    end

    assign t_lo  = hpr_pkg::T_W'(r_a) * hpr_pkg::T_W'(hpr_pkg::PH_LO_MUL)
                 + hpr_pkg::T_W'(hpr_pkg::PH_RND);
    // The reciprocal estimate is at most one below the true quotient.
    assign recip = 55'(r_u1) * 55'(hpr_pkg::RECIP_M);

    always_comb begin
        rem = r_u2 - hpr_pkg::U_W'(r_qe * hpr_pkg::DIV_REM);
        q   = r_qe + hpr_pkg::QE_W'(rem >= hpr_pkg::U_W'(hpr_pkg::DIV_REM));
        p   = r_hi2 + 32'(q);
        z0  = 33'(signed'(p));
        n_cord.x   = hpr_pkg::CORDIC_GAIN;
        n_cord.y   = '0;
        n_cord.neg = 1'b0;
        if (z0 > QTR_TURN) begin
            z0         = z0 - HALF_TURN;
            n_cord.neg = 1'b1;
        end else if (z0 < -QTR_TURN) begin
            z0         = z0 + HALF_TURN;
            n_cord.neg = 1'b1;
        end
        n_cord.z = z0[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_a <= n_a;
        end
        if (i_en[1]) begin
            r_u1  <= t_lo[hpr_pkg::T_W-1:5];
            r_hi1 <= 32'(r_a) * 32'(hpr_pkg::PH_HI_MUL);
        end
        if (i_en[2]) begin
            r_qe  <= recip[hpr_pkg::RECIP_SH +: hpr_pkg::QE_W];
            r_u2  <= r_u1;
            r_hi2 <= r_hi1;
        end
        if (i_en[3]) begin
            r_cord <= n_cord;
        end
    end

    assign o_cord = r_cord;

endmodule

/* rtl/hpr_cordic_cell.sv */
// One CORDIC rotation step with its output register.
`timescale 1ns / 1ps

module hpr_cordic_cell (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic [hpr_pkg::SHIFT_W-1:0]        i_shift,
    input  logic [hpr_pkg::CORDIC_W-1:0]       i_atan,
    input  hpr_pkg::t_cord                     i_d,
    output hpr_pkg::t_cord                     o_q
);

    hpr_pkg::t_cord r_q;
    hpr_pkg::t_cord n_q;
    logic signed [hpr_pkg::CORDIC_W-1:0] dx;
    logic signed [hpr_pkg::CORDIC_W-1:0] dy;

    always_comb begin
        dx      = i_d.y >>> i_shift;
        dy      = i_d.x >>> i_shift;
        n_q.neg = i_d.neg;
        if (i_d.z >= 0) begin
            n_q.x = i_d.x - dx;
            n_q.y = i_d.y + dy;
            n_q.z = i_d.z - signed'(i_atan);
        end else begin
            n_q.x = i_d.x + dx;
            n_q.y = i_d.y - dy;
            n_q.z = i_d.z + signed'(i_atan);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

/* rtl/hpr_rotate.sv */
// Trig formatting, rotation matrix coefficients and velocity rotation.
`timescale 1ns / 1ps

module hpr_rotate (
    input  logic                             i_clk,
    input  logic [hpr_pkg::ROT_STAGES-1:0]   i_en,
    input  hpr_pkg::t_cord                   i_hd,
    input  hpr_pkg::t_cord                   i_pt,
    input  hpr_pkg::t_cord                   i_rl,
    input  hpr_pkg::t_vec3                   i_vel,
    output hpr_pkg::t_vec3                   o_res
);

    typedef struct packed {
        hpr_pkg::t_trig chcr;
        hpr_pkg::t_trig shcp;
        hpr_pkg::t_trig chsr;
        hpr_pkg::t_trig shcr;
        hpr_pkg::t_trig chcp;
        hpr_pkg::t_trig shsr;
        hpr_pkg::t_trig cpsr;
        hpr_pkg::t_trig cpcr;
        hpr_pkg::t_trig sp;
    } t_prod;

    hpr_pkg::t_trig r_ch, r_sh, r_cp, r_sp, r_cr, r_sr;
    hpr_pkg::t_trig r_shsp, r_chsp, r_sr1, r_cr1;
    t_prod          r_p0, r_p1;
    hpr_pkg::t_trig r_shsp_sr, r_shsp_cr, r_chsp_sr, r_chsp_cr;
    hpr_pkg::t_coef r_es, r_ef, r_em, r_ns, r_nf, r_nm, r_us, r_uf, r_um;
    hpr_pkg::t_term r_t [9];
    hpr_pkg::t_vec3 r_vel [4];
    hpr_pkg::t_vec3 r_res;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_ch     <= hpr_pkg::trig_fmt(i_hd.x, i_hd.neg);
            r_sh     <= hpr_pkg::trig_fmt(i_hd.y, i_hd.neg);
            r_cp     <= hpr_pkg::trig_fmt(i_pt.x, i_pt.neg);
            r_sp     <= hpr_pkg::trig_fmt(i_pt.y, i_pt.neg);
            r_cr     <= hpr_pkg::trig_fmt(i_rl.x, i_rl.neg);
            r_sr     <= hpr_pkg::trig_fmt(i_rl.y, i_rl.neg);
            r_vel[0] <= i_vel;
        end
        if (i_en[1]) begin
            r_shsp    <= hpr_pkg::tmul(r_sh, r_sp);
            r_chsp    <= hpr_pkg::tmul(r_ch, r_sp);
            r_sr1     <= r_sr;
            r_cr1     <= r_cr;
            r_p0.chcr <= hpr_pkg::tmul(r_ch, r_cr);
            r_p0.shcp <= hpr_pkg::tmul(r_sh, r_cp);
            r_p0.chsr <= hpr_pkg::tmul(r_ch, r_sr);
            r_p0.shcr <= hpr_pkg::tmul(r_sh, r_cr);
            r_p0.chcp <= hpr_pkg::tmul(r_ch, r_cp);
            r_p0.shsr <= hpr_pkg::tmul(r_sh, r_sr);
            r_p0.cpsr <= hpr_pkg::tmul(r_cp, r_sr);
            r_p0.cpcr <= hpr_pkg::tmul(r_cp, r_cr);
            r_p0.sp   <= r_sp;
            r_vel[1]  <= r_vel[0];
        end
        if (i_en[2]) begin
            r_shsp_sr <= hpr_pkg::tmul(r_shsp, r_sr1);
            r_shsp_cr <= hpr_pkg::tmul(r_shsp, r_cr1);
            r_chsp_sr <= hpr_pkg::tmul(r_chsp, r_sr1);
            r_chsp_cr <= hpr_pkg::tmul(r_chsp, r_cr1);
            r_p1      <= r_p0;
            r_vel[2]  <= r_vel[1];
        end
        if (i_en[3]) begin
            r_es <= hpr_pkg::COEF_W'(r_p1.chcr) + hpr_pkg::COEF_W'(r_shsp_sr);
            r_ef <= hpr_pkg::COEF_W'(r_p1.shcp);
            r_em <= hpr_pkg::COEF_W'(r_p1.chsr) - hpr_pkg::COEF_W'(r_shsp_cr);
            r_ns <= hpr_pkg::COEF_W'(r_chsp_sr) - hpr_pkg::COEF_W'(r_p1.shcr);
            r_nf <= hpr_pkg::COEF_W'(r_p1.chcp);
            r_nm <= -hpr_pkg::COEF_W'(r_p1.shsr) - hpr_pkg::COEF_W'(r_chsp_cr);
            r_us <= -hpr_pkg::COEF_W'(r_p1.cpsr);
            r_uf <= hpr_pkg::COEF_W'(r_p1.sp);
            r_um <= hpr_pkg::COEF_W'(r_p1.cpcr);
            r_vel[3] <= r_vel[2];
        end
        if (i_en[4]) begin
            r_t[0] <= hpr_pkg::vmul(r_vel[3].c0, r_es);
            r_t[1] <= hpr_pkg::vmul(r_vel[3].c1, r_ef);
            r_t[2] <= hpr_pkg::vmul(r_vel[3].c2, r_em);
            r_t[3] <= hpr_pkg::vmul(r_vel[3].c0, r_ns);
            r_t[4] <= hpr_pkg::vmul(r_vel[3].c1, r_nf);
            r_t[5] <= hpr_pkg::vmul(r_vel[3].c2, r_nm);
            r_t[6] <= hpr_pkg::vmul(r_vel[3].c0, r_us);
            r_t[7] <= hpr_pkg::vmul(r_vel[3].c1, r_uf);
            r_t[8] <= hpr_pkg::vmul(r_vel[3].c2, r_um);
        end
        if (i_en[5]) begin
            r_res.c0 <= hpr_pkg::sat_vel(hpr_pkg::SUM_W'(r_t[0]) + hpr_pkg::SUM_W'(r_t[1])
                                       + hpr_pkg::SUM_W'(r_t[2]));
            r_res.c1 <= hpr_pkg::sat_vel(hpr_pkg::SUM_W'(r_t[3]) + hpr_pkg::SUM_W'(r_t[4])
                                       + hpr_pkg::SUM_W'(r_t[5]));
            r_res.c2 <= hpr_pkg::sat_vel(hpr_pkg::SUM_W'(r_t[6]) + hpr_pkg::SUM_W'(r_t[7])
                                       + hpr_pkg::SUM_W'(r_t[8]));
        end
    end

    assign o_res = r_res;

endmodule

/* rtl/heading_pitch_roll_rotate.sv */
// Top level: heading-pitch-roll velocity rotation over a pipelined CORDIC cell chain.
//
//  Port group   Dir   tdata fields, lowest bit first
//  s_*          in    heading_cdeg, pitch_cdeg, roll_cdeg, vel_starboard, vel_forward, vel_mast
//  m_*          out   vel_east, vel_north, vel_up
//
// One word enters per cycle unless a full pipeline waits on m_tready. The stages are 4 phase stages, 30 CORDIC cells,
// one trig stage and five stages of matrix and velocity arithmetic, the last of which
// is the output register. Each stage loads when it is empty or its successor loads, so
// bubbles close up and input is taken while a result waits on m_tready.
// Reset clears only the stage valid bits.
`timescale 1ns / 1ps

module heading_pitch_roll_rotate (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // heading_cdeg, pitch_cdeg, roll_cdeg, vel_starboard, vel_forward, vel_mast, zero pad
    input  logic [hpr_pkg::IN_TW-1:0]   s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // vel_east, vel_north, vel_up
    output logic [hpr_pkg::OUT_TW-1:0]  m_tdata
);

    `include "assert_macros.svh"

    localparam int AW = hpr_pkg::ANG_W;
    localparam int VW = hpr_pkg::VEL_W;
    localparam int NI = hpr_pkg::CORDIC_ITERS;
    localparam int PS = hpr_pkg::PH_STAGES;

    logic [hpr_pkg::NSTG-1:0] r_vld;
    logic [hpr_pkg::NSTG-1:0] n_vld;
    logic [hpr_pkg::NSTG-1:0] en;

    hpr_pkg::t_vec3 in_vel;
    hpr_pkg::t_vec3 r_vel [hpr_pkg::VEL_DLY];
    hpr_pkg::t_vec3 res;
    hpr_pkg::t_cord chain [3][NI+1];

    assign en[hpr_pkg::NSTG-1] = !r_vld[hpr_pkg::NSTG-1] || m_tready;
    genvar k;
    generate
        for (k = 0; k < hpr_pkg::NSTG - 1; k++) begin : g_en
            assign en[k] = !r_vld[k] || en[k+1];
        end
    endgenerate

    assign n_vld = {r_vld[hpr_pkg::NSTG-2:0], s_tvalid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= (en & n_vld) | (~en & r_vld);
        end
    end

    assign in_vel.c0 = s_tdata[3*AW +: VW];
    assign in_vel.c1 = s_tdata[3*AW+VW +: VW];
    assign in_vel.c2 = s_tdata[3*AW+2*VW +: VW];

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_vel[0] <= in_vel;
        end
        for (int j = 1; j < hpr_pkg::VEL_DLY; j++) begin
            if (en[j]) begin
                r_vel[j] <= r_vel[j-1];
            end
        end
    end

    genvar l, c;
    generate
        for (l = 0; l < 3; l++) begin : g_lane
            hpr_phase u_phase (
                .i_clk  (i_clk),
                .i_en   (en[PS-1:0]),
                .i_ang  (s_tdata[l*AW +: AW]),
                .o_cord (chain[l][0])
            );
            for (c = 0; c < NI; c++) begin : g_cell
                hpr_cordic_cell u_cell (
                    .i_clk   (i_clk),
                    .i_en    (en[PS+c]),
                    .i_shift (hpr_pkg::SHIFT_W'(c)),
                    .i_atan  (hpr_pkg::ATAN[c]),
                    .i_d     (chain[l][c]),
                    .o_q     (chain[l][c+1])
                );
            end
        end
    endgenerate

    hpr_rotate u_rotate (
        .i_clk (i_clk),
        .i_en  (en[hpr_pkg::NSTG-1:hpr_pkg::VEL_DLY]),
        .i_hd  (chain[0][NI]),
        .i_pt  (chain[1][NI]),
        .i_rl  (chain[2][NI]),
        .i_vel (r_vel[hpr_pkg::VEL_DLY-1]),
        .o_res (res)
    );

    assign s_tready = en[0];
    assign m_tvalid = r_vld[hpr_pkg::NSTG-1];
    assign m_tdata  = hpr_pkg::OUT_TW'({res.c2, res.c1, res.c0});

    `HPR_ASSERT(a_accept_fills, i_clk, i_rst_n, (s_tvalid && s_tready) |=> r_vld[0], "accepted word lost at stage 0")
    `HPR_ASSERT(a_empty_ready, i_clk, i_rst_n, (!r_vld[0]) |-> s_tready, "input stalled with an empty first stage")
    `HPR_ASSERT(a_out_moves, i_clk, i_rst_n, (m_tvalid && m_tready && r_vld[hpr_pkg::NSTG-2]) |=> m_tvalid, "result dropped behind a taken word")
    `HPR_ASSERT_ALWAYS(a_reset_empty, i_clk, (!i_rst_n) |=> !m_tvalid, "output valid right after reset")

endmodule
